FILE: sv/hysteresis_relay_controller_macros.svh
// assertion macros shared by the relay controller
`ifndef HYSTERESIS_RELAY_CONTROLLER_MACROS_SVH
`define HYSTERESIS_RELAY_CONTROLLER_MACROS_SVH

// property that must hold at every clock edge out of reset
`define HRC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in this cycle implies consequent in the next
`define HRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/hrc_pkg.sv
// shared types, codes and constants of the relay controller
package hrc_pkg;

    localparam int DELAY_SHIFT_DEFAULT = 7;
    localparam int CountW              = 16;
    localparam logic [CountW-1:0] COUNT_MAX = '1;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_HOT_MODE      = 3'd0,
        REG_THRESHOLD     = 3'd1,
        REG_HYSTERESIS    = 3'd2,
        REG_RANGE_PROTECT = 3'd3,
        REG_LOW_LIMIT     = 3'd4,
        REG_HIGH_LIMIT    = 3'd5,
        REG_SWITCH_DELAY  = 3'd6,
        REG_FORCE_MODE    = 3'd7
    } reg_index_t;

    // force codes, the unused code behaves as automatic
    typedef enum logic [1:0] {
        FORCE_AUTO = 2'd0,
        FORCE_ON   = 2'd1,
        FORCE_OFF  = 2'd2
    } force_t;

    localparam logic signed [11:0] THRESHOLD_RESET = 12'sd280;
    localparam logic [7:0]         HYSTERESIS_RESET = 8'd20;
    localparam logic signed [7:0]  LOW_LIMIT_RESET = -8'sd50;
    localparam logic signed [7:0]  HIGH_LIMIT_RESET = 8'sd110;
    // release level of the reset threshold
    localparam logic signed [11:0] RELEASE_RESET = 12'sd382;

    typedef struct packed {
        logic              hot_mode;
        logic signed [11:0] threshold;
        logic [7:0]        hysteresis;
        logic              range_protect;
        logic signed [7:0] low_limit;
        logic signed [7:0] high_limit;
        logic [3:0]        switch_delay;
        logic [1:0]        force_mode;
        logic signed [11:0] release_level;
    } cfg_t;

    // trunc((13*thr + 4000) / 20): divide the magnitude by 4, then by 5 via reciprocal
    function automatic logic signed [11:0] release_of(input logic signed [11:0] thr);
        logic signed [15:0] x;
        logic [14:0]        ax;
        logic [12:0]        y;
        logic [28:0]        prod;
        logic signed [11:0] res;
        x    = 16'(thr) * 16'sd13 + 16'sd4000;
        ax   = x[15] ? 15'(-x) : x[14:0];
        y    = ax[14:2];
        prod = 29'(y) * 29'd52429;
        res  = $signed({1'b0, prod[28:18]});
        return x[15] ? -res : res;
    endfunction

endpackage

FILE: sv/hrc_in_if.sv
// sensor reading request channel
interface hrc_in_if;
    logic              valid;
    logic              ready;
    logic signed [11:0] reading;

    modport source (output valid, output reading, input ready);
    modport sink (input valid, input reading, output ready);
endinterface

FILE: sv/hrc_out_if.sv
// relay result channel
interface hrc_out_if;
    logic valid;
    logic ready;
    logic relay_on;
    logic latched_on;
    logic out_of_range;

    modport source (output valid, output relay_on, output latched_on, output out_of_range,
                    input ready);
    modport sink (input valid, input relay_on, input latched_on, input out_of_range,
                  output ready);
endinterface

FILE: sv/hrc_cfg_if.sv
// configuration write channel
interface hrc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [11:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: sv/hrc_cfg.sv
// configuration register file with precomputed release level
module hrc_cfg (
    input  logic          clk,
    input  logic          rst_n,
    hrc_cfg_if.sink       cfg,
    output hrc_pkg::cfg_t cfg_q
);

    hrc_pkg::cfg_t cfg_reg;
    hrc_pkg::cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (hrc_pkg::reg_index_t'(cfg.index))
                hrc_pkg::REG_HOT_MODE:      cfg_next.hot_mode = cfg.data[0];
                hrc_pkg::REG_THRESHOLD:
                begin
                    cfg_next.threshold     = $signed(cfg.data);
                    // release level follows the threshold, kept off the tick path
                    cfg_next.release_level = hrc_pkg::release_of($signed(cfg.data));
                end
                hrc_pkg::REG_HYSTERESIS:    cfg_next.hysteresis = cfg.data[7:0];
                hrc_pkg::REG_RANGE_PROTECT: cfg_next.range_protect = cfg.data[0];
                hrc_pkg::REG_LOW_LIMIT:     cfg_next.low_limit = $signed(cfg.data[7:0]);
                hrc_pkg::REG_HIGH_LIMIT:    cfg_next.high_limit = $signed(cfg.data[7:0]);
                hrc_pkg::REG_SWITCH_DELAY:  cfg_next.switch_delay = cfg.data[3:0];
                hrc_pkg::REG_FORCE_MODE:    cfg_next.force_mode = cfg.data[1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hot_mode      <= 1'b0;
            cfg_reg.threshold     <= hrc_pkg::THRESHOLD_RESET;
            cfg_reg.hysteresis    <= hrc_pkg::HYSTERESIS_RESET;
            cfg_reg.range_protect <= 1'b0;
            cfg_reg.low_limit     <= hrc_pkg::LOW_LIMIT_RESET;
            cfg_reg.high_limit    <= hrc_pkg::HIGH_LIMIT_RESET;
            cfg_reg.switch_delay  <= 4'd0;
            cfg_reg.force_mode    <= hrc_pkg::FORCE_AUTO;
            cfg_reg.release_level <= hrc_pkg::RELEASE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: sv/hysteresis_relay_controller.sv
// hysteresis relay controller top level
// sample: one signed sensor reading per request, taken when valid and ready are high.
// result: one request per reading with relay_on, latched_on and out_of_range.
// cfg: register writes by index, always ready; write only while no reading is in flight.
// each reading enters an input register; the decision, the latch and the tick counter
// update between that register and the result register, which drives result.valid.
// throughput is one reading per cycle while result.ready stays high; the single pass
// of compare and counter logic per tick sets that figure.
// when result is stalled the result register holds and the input register keeps one
// more reading, after which sample.ready drops until result.ready returns.
// reset clears the latch and the tick counter, empties both registers and loads the
// default register values (threshold 280, hysteresis 20, limits -50 and 110).
// a latch change waits until the tick counter exceeds switch_delay << DELAY_SHIFT;
// the counter restarts at one on a change, clears on a protection trip and saturates at its top.
`include "hysteresis_relay_controller_macros.svh"

module hysteresis_relay_controller #(
    parameter int DELAY_SHIFT = hrc_pkg::DELAY_SHIFT_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    hrc_in_if.sink    sample,
    hrc_out_if.source result,
    hrc_cfg_if.sink   cfg
);

    localparam int LimW = 4 + DELAY_SHIFT;

    hrc_pkg::cfg_t cfg_q;

    hrc_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    logic                      in_valid_reg, in_valid_next;
    logic signed [11:0]        reading_reg;
    logic                      out_valid_reg, out_valid_next;
    logic                      relay_reg, latched_reg, oor_reg;
    logic                      engaged_reg, engaged_next;
    logic [hrc_pkg::CountW-1:0] tick_count_reg, tick_count_next;

    logic                      advance;
    logic signed [13:0]        temp, temp_v, hold_v, rel_v, engage_level, lo10, hi10, lo_x, hi_x;
    logic [LimW-1:0]           limit;
    logic                      can_switch, trip, change, drive;
    logic [hrc_pkg::CountW-1:0] count_base;

    assign advance      = in_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !in_valid_reg || !out_valid_reg || result.ready;

    // range check on the raw reading
    assign temp = 14'(reading_reg);
    assign lo_x = 14'(cfg_q.low_limit);
    assign hi_x = 14'(cfg_q.high_limit);
    assign lo10 = (lo_x <<< 3) + (lo_x <<< 1);
    assign hi10 = (hi_x <<< 3) + (hi_x <<< 1);
    assign trip = cfg_q.range_protect && (temp < lo10 || temp > hi10);

    // heating flips the sense of the engage and release comparisons
    assign temp_v       = cfg_q.hot_mode ? -temp : temp;
    assign hold_v       = cfg_q.hot_mode ? -14'(cfg_q.threshold) : 14'(cfg_q.threshold);
    assign rel_v        = cfg_q.hot_mode ? -14'(cfg_q.release_level)
                                         : 14'(cfg_q.release_level);
    assign engage_level = hold_v + $signed({6'b0, cfg_q.hysteresis});

    assign limit      = LimW'(cfg_q.switch_delay) << DELAY_SHIFT;
    assign can_switch = hrc_pkg::CountW'(limit) < tick_count_reg;
    assign change     = can_switch && (engaged_reg ? (temp_v <= rel_v)
                                                   : (temp_v >= engage_level));

    always_comb
    begin
        engaged_next    = engaged_reg;
        tick_count_next = tick_count_reg;
        count_base      = change ? '0 : tick_count_reg;
        if (advance)
        begin
            if (trip)
            begin
                tick_count_next = '0;
            end
            else
            begin
                engaged_next    = engaged_reg ^ change;
                tick_count_next = (count_base < hrc_pkg::COUNT_MAX) ? count_base + 1'b1
                                                                    : count_base;
            end
        end
    end

    always_comb
    begin
        priority if (hrc_pkg::force_t'(cfg_q.force_mode) == hrc_pkg::FORCE_ON)
            drive = 1'b1;
        else if (hrc_pkg::force_t'(cfg_q.force_mode) == hrc_pkg::FORCE_OFF)
            drive = 1'b0;
        else
            drive = engaged_reg ^ change;
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (sample.valid && sample.ready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            engaged_reg    <= 1'b0;
            tick_count_reg <= '0;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            out_valid_reg  <= out_valid_next;
            engaged_reg    <= engaged_next;
            tick_count_reg <= tick_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
            reading_reg <= sample.reading;
        if (advance)
        begin
            relay_reg   <= trip ? 1'b0 : drive;
            latched_reg <= engaged_next;
            oor_reg     <= trip;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.relay_on     = relay_reg;
    assign result.latched_on   = latched_reg;
    assign result.out_of_range = oor_reg;

    `HRC_ASSERT(trip_drives_off, !result.valid || !result.out_of_range || !result.relay_on, "protection trip with relay on")
    `HRC_ASSERT_NEXT(change_restarts_count, advance && !trip && change, tick_count_reg == 16'd1, "counter not restarted after latch change")
    `HRC_ASSERT_NEXT(trip_keeps_latch, advance && trip, tick_count_reg == '0 && engaged_reg == $past(engaged_reg), "trip altered latch or counter")
    `HRC_ASSERT_NEXT(force_on_drives, advance && !trip && cfg_q.force_mode == hrc_pkg::FORCE_ON, result.relay_on, "force on not applied")

endmodule
